// ----- hw/rtl/dep_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the double-ended priority queue.
// No dependencies; used by every module of the block.
package dep_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned KIND_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT     = 2'd0,
    KIND_REMOVE_MAX = 2'd1,
    KIND_REMOVE_MIN = 2'd2
  } kind_e;

  // per-cycle command to one sorted chain
  typedef struct packed {
    logic insert;     // place new value in order, shift the entries that belong after it outward
    logic pop_head;   // every cell takes its outer neighbor's entry
    logic drop_tail;  // last valid cell goes invalid
  } chain_cmd_t;

  // what a cell shows to its neighbors
  typedef struct packed {
    logic                      valid;
    logic                      moves;  // entry steps outward on insert
    logic signed [VALUE_W-1:0] value;
  } cell_link_t;

endpackage

// ----- hw/rtl/dep_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of a sorted chain: holds one entry and its valid bit.
// Depends on dep_pkg.
module dep_cell #(
  parameter bit DESCEND = 1'b0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dep_pkg::chain_cmd_t               cmd_i,
  input  logic signed [dep_pkg::VALUE_W-1:0] ins_value_i,
  input  dep_pkg::cell_link_t               left_i,
  input  dep_pkg::cell_link_t               right_i,
  output dep_pkg::cell_link_t               link_o
);
  import dep_pkg::*;

  logic                      valid_q, valid_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic                      moves;

  // entry belongs after the new value
  assign moves = valid_q & (DESCEND ? (value_q < ins_value_i) : (value_q > ins_value_i));

  assign link_o = '{valid: valid_q, moves: moves, value: value_q};

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    priority if (cmd_i.insert) begin
      valid_d = valid_q | left_i.valid;
      if (left_i.moves) begin
        value_d = left_i.value;
      end else if (moves || !valid_q) begin
        value_d = ins_value_i;
      end
    end else if (cmd_i.pop_head) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end else if (cmd_i.drop_tail) begin
      valid_d = right_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ----- hw/rtl/dep_chain.sv -----
`timescale 1ns / 1ps
// Sorted chain of dep_cell instances; the head cell holds the extreme entry.
// Depends on dep_pkg and dep_cell.
module dep_chain #(
  parameter int unsigned CAPACITY = 1024,
  parameter bit          DESCEND  = 1'b0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dep_pkg::chain_cmd_t                cmd_i,
  input  logic signed [dep_pkg::VALUE_W-1:0] ins_value_i,
  output logic signed [dep_pkg::VALUE_W-1:0] head_o
);
  import dep_pkg::*;

  localparam cell_link_t LEFT_EDGE  = '{valid: 1'b1, moves: 1'b0, value: '0};
  localparam cell_link_t RIGHT_EDGE = '{valid: 1'b0, moves: 1'b0, value: '0};

  cell_link_t links [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left, right;
    if (i == 0) begin : g_first
      assign left = LEFT_EDGE;
    end else begin : g_mid_l
      assign left = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = RIGHT_EDGE;
    end else begin : g_mid_r
      assign right = links[i+1];
    end
    dep_cell #(.DESCEND(DESCEND)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd_i),
      .ins_value_i(ins_value_i),
      .left_i     (left),
      .right_i    (right),
      .link_o     (links[i])
    );
  end

  assign head_o = links[0].value;

endmodule

// ----- hw/rtl/double_ended_priority_queue_core.sv -----
`timescale 1ns / 1ps
// Double-ended priority queue over two mirrored sorted cell chains.
// Registered: the chains update on the accept edge, then the output register loads
// the result once it is empty or taken; no new item is accepted before that load.
// A result waiting on m_axis_tready holds off the following item.
// Reset (async, active low) clears count, cell valid bits and handshake flags; no clearing pass.
module double_ended_priority_queue_core #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [dep_pkg::VALUE_W-1:0]           s_axis_tdata,  // value
  input  logic [dep_pkg::KIND_W-1:0]            s_axis_tuser,  // kind
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // max_value, min_value, count, zero pad
  output logic [((2*dep_pkg::VALUE_W + $clog2(CAPACITY+1) + 7)/8)*8-1:0] m_axis_tdata,
  output logic                                  m_axis_tuser   // rejected
);
  import dep_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned OUT_W = ((2*VALUE_W + CNT_W + 7) / 8) * 8;

  kind_e                     kind;
  logic                      accept, empty, full, rej_d, out_load;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      pend_q, rej_q, m_valid_q;
  logic [OUT_W-1:0]          m_data_q;
  logic                      m_user_q;
  chain_cmd_t                cmd_asc, cmd_desc;
  logic signed [VALUE_W-1:0] head_asc, head_desc, max_v, min_v;

  assign kind          = kind_e'(s_axis_tuser);
  assign s_axis_tready = !pend_q;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign empty         = (count_q == '0);
  assign full          = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    cmd_asc  = '0;
    cmd_desc = '0;
    rej_d    = 1'b0;
    count_d  = count_q;
    if (accept) begin
      unique case (kind)
        KIND_INSERT: begin
          if (full) begin
            rej_d = 1'b1;
          end else begin
            cmd_asc.insert  = 1'b1;
            cmd_desc.insert = 1'b1;
            count_d         = count_q + CNT_W'(1);
          end
        end
        KIND_REMOVE_MAX: begin
          if (empty) begin
            rej_d = 1'b1;
          end else begin
            cmd_desc.pop_head = 1'b1;
            cmd_asc.drop_tail = 1'b1;
            count_d           = count_q - CNT_W'(1);
          end
        end
        KIND_REMOVE_MIN: begin
          if (empty) begin
            rej_d = 1'b1;
          end else begin
            cmd_asc.pop_head   = 1'b1;
            cmd_desc.drop_tail = 1'b1;
            count_d            = count_q - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  dep_chain #(.CAPACITY(CAPACITY), .DESCEND(1'b0)) u_asc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_asc),
    .ins_value_i(signed'(s_axis_tdata)),
    .head_o     (head_asc)
  );

  dep_chain #(.CAPACITY(CAPACITY), .DESCEND(1'b1)) u_desc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_desc),
    .ins_value_i(signed'(s_axis_tdata)),
    .head_o     (head_desc)
  );

  assign max_v    = empty ? '0 : head_desc;
  assign min_v    = empty ? '0 : head_asc;
  assign out_load = pend_q & (!m_valid_q | m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        pend_q <= 1'b1;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rej_q <= rej_d;
    end
    if (out_load) begin
      m_data_q <= OUT_W'({count_q, min_v, max_v});
      m_user_q <= rej_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ----- hw/rtl/dep_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for double_ended_priority_queue_core, bound to the top level.
// Depends on dep_pkg.
module dep_checker #(
  parameter int unsigned CAPACITY = 1024
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [((2*dep_pkg::VALUE_W + $clog2(CAPACITY+1) + 7)/8)*8-1:0] m_axis_tdata,
  input logic                                  m_axis_tuser
);
  import dep_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic signed [VALUE_W-1:0] max_f, min_f;
  logic [CNT_W-1:0]          cnt_f;

  assign max_f = signed'(m_axis_tdata[VALUE_W-1:0]);
  assign min_f = signed'(m_axis_tdata[2*VALUE_W-1:VALUE_W]);
  assign cnt_f = m_axis_tdata[2*VALUE_W +: CNT_W];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && cnt_f == '0 |-> max_f == '0 && min_f == '0)
    else $error("empty store reports nonzero extreme");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && cnt_f != '0 |-> max_f >= min_f)
    else $error("max below min");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_f <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  // an item is only refused on an empty or a full store
  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> cnt_f == '0 || cnt_f == CNT_W'(CAPACITY))
    else $error("reject flag with store neither empty nor full");

endmodule

bind double_ended_priority_queue_core dep_checker #(.CAPACITY(CAPACITY)) u_dep_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ----- bench/tb_double_ended_priority_queue_core.sv -----
`timescale 1ns / 1ps
// Testbench for double_ended_priority_queue_core: a sorted-queue predictor checks
// max, min, count and the reject flag of every result item.
// Depends on dep_pkg and the core RTL only.
module tb_double_ended_priority_queue_core;
  import dep_pkg::*;

  localparam int unsigned CAPACITY     = 1024;
  localparam int unsigned COUNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned RES_W        = ((2 * VALUE_W + COUNT_W + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef struct {
    logic signed [VALUE_W-1:0] max_value;
    logic signed [VALUE_W-1:0] min_value;
    logic [COUNT_W-1:0]        count;
    logic                      rejected;
  } queue_status_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [VALUE_W-1:0] s_axis_tdata;
  logic [KIND_W-1:0]  s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [RES_W-1:0]   m_axis_tdata;
  logic               m_axis_tuser;

  logic signed [VALUE_W-1:0] sorted_values[$];
  queue_status_t             expected_status_q[$];
  int unsigned               error_count = 0;
  int unsigned               cycle_count = 0;
  int unsigned               send_idle_pct;
  int unsigned               recv_idle_pct;

  double_ended_priority_queue_core #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_status_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // new state of the sorted store after one item, and the status it reports
  function automatic queue_status_t step_sorted_store(input logic [KIND_W-1:0] kind,
                                                      input logic signed [VALUE_W-1:0] value);
    queue_status_t st;
    int            pos;
    st.rejected = 1'b0;
    if (kind == KIND_INSERT) begin
      if (sorted_values.size() >= CAPACITY) begin
        st.rejected = 1'b1;
      end else begin
        pos = sorted_values.size();
        while (pos > 0 && sorted_values[pos-1] > value) pos--;
        sorted_values.insert(pos, value);
      end
    end else if (kind == KIND_REMOVE_MAX) begin
      if (sorted_values.size() == 0) st.rejected = 1'b1;
      else void'(sorted_values.pop_back());
    end else if (kind == KIND_REMOVE_MIN) begin
      if (sorted_values.size() == 0) st.rejected = 1'b1;
      else void'(sorted_values.pop_front());
    end
    if (sorted_values.size() > 0) begin
      st.max_value = sorted_values[sorted_values.size()-1];
      st.min_value = sorted_values[0];
    end else begin
      st.max_value = '0;
      st.min_value = '0;
    end
    st.count = COUNT_W'(sorted_values.size());
    return st;
  endfunction

  always @(posedge clk_i) begin : check_results
    queue_status_t             want;
    logic signed [VALUE_W-1:0] got_max;
    logic signed [VALUE_W-1:0] got_min;
    logic [COUNT_W-1:0]        got_count;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_max   = m_axis_tdata[VALUE_W-1:0];
      got_min   = m_axis_tdata[2*VALUE_W-1:VALUE_W];
      got_count = m_axis_tdata[2*VALUE_W+COUNT_W-1:2*VALUE_W];
      if (expected_status_q.size() == 0) begin
        report_error($sformatf("unexpected result max=%0d min=%0d count=%0d rej=%0b",
                               got_max, got_min, got_count, m_axis_tuser));
      end else begin
        want = expected_status_q.pop_front();
        if (got_max !== want.max_value)
          report_error($sformatf("max_value %0d, want %0d", got_max, want.max_value));
        if (got_min !== want.min_value)
          report_error($sformatf("min_value %0d, want %0d", got_min, want.min_value));
        if (got_count !== want.count)
          report_error($sformatf("count %0d, want %0d", got_count, want.count));
        if (m_axis_tuser !== want.rejected)
          report_error($sformatf("rejected %0b, want %0b", m_axis_tuser, want.rejected));
      end
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_status_q.insert(expected_status_q.size(),
                             step_sorted_store(kind, $signed(value)));
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
  endtask

  // extremes and small clustered values mixed in so duplicates are common
  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return VALUE_W'($urandom_range(16)) - 32'd8;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic test_directed_cases();
    send_item(KIND_REMOVE_MAX, 32'd0);
    send_item(KIND_REMOVE_MIN, 32'hFFFF_FFFF);
    send_item(KIND_UNUSED, 32'd0);
    send_item(KIND_INSERT, VAL_MAX);
    send_item(KIND_INSERT, VAL_MIN);
    send_item(KIND_INSERT, 32'd0);
    send_item(KIND_INSERT, 32'hFFFF_FFFF);
    send_item(KIND_INSERT, 32'd1);
    send_item(KIND_INSERT, 32'd7);
    send_item(KIND_INSERT, 32'd7);
    send_item(KIND_UNUSED, 32'h5555_AAAA);
    send_item(KIND_INSERT, VAL_MAX);
    send_item(KIND_REMOVE_MAX, 32'd0);
    send_item(KIND_REMOVE_MAX, 32'd0);
    send_item(KIND_REMOVE_MAX, 32'd0);
    send_item(KIND_REMOVE_MIN, 32'd0);
    send_item(KIND_INSERT, VAL_MIN);
    send_item(KIND_REMOVE_MIN, 32'd0);
    send_item(KIND_REMOVE_MIN, 32'd0);
    send_item(KIND_REMOVE_MAX, 32'd0);
    send_item(KIND_REMOVE_MIN, 32'd0);
    send_item(KIND_REMOVE_MIN, 32'd0);
    send_item(KIND_REMOVE_MAX, 32'd0);
    wait_results_done();
  endtask

  task automatic test_fill_to_capacity();
    while (sorted_values.size() < CAPACITY) send_item(KIND_INSERT, rand_value());
    // full: inserts bounce, other kinds still work
    send_item(KIND_INSERT, VAL_MAX);
    send_item(KIND_INSERT, VAL_MIN);
    send_item(KIND_UNUSED, 32'd0);
    send_item(KIND_REMOVE_MAX, 32'd0);
    send_item(KIND_INSERT, rand_value());
    send_item(KIND_INSERT, rand_value());
    send_item(KIND_REMOVE_MIN, 32'd0);
    send_item(KIND_INSERT, 32'd0);
    wait_results_done();
  endtask

  task automatic test_random_mix(input int unsigned n_items);
    int unsigned insert_pct;
    int unsigned pick;
    insert_pct = 50;
    for (int unsigned i = 0; i < n_items; i++) begin
      // bursts lean toward growing or shrinking the store
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          default: insert_pct = 75;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 3) send_item(KIND_UNUSED, VALUE_W'($urandom));
      else if (pick < insert_pct) send_item(KIND_INSERT, rand_value());
      else if ($urandom_range(1) == 0) send_item(KIND_REMOVE_MAX, VALUE_W'($urandom));
      else send_item(KIND_REMOVE_MIN, VALUE_W'($urandom));
      if ($urandom_range(199) == 0) wait_results_done();
    end
    wait_results_done();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_INSERT;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 14;
    recv_idle_pct = 46;
    test_directed_cases();
    test_fill_to_capacity();
    test_random_mix(RANDOM_ITEMS / 3);

    send_idle_pct = 46;
    recv_idle_pct = 14;
    test_random_mix(RANDOM_ITEMS / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(RANDOM_ITEMS / 3);

    wait_results_done();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
